// ===== rtl/multilook_box_average_decimator_defines.svh =====
// Assertion macros for the multilook box average decimator.
// Used by the top level; the bodies expect clk and rst_n in scope.
`ifndef MULTILOOK_BOX_AVERAGE_DECIMATOR_DEFINES_SVH
`define MULTILOOK_BOX_AVERAGE_DECIMATOR_DEFINES_SVH
`ifndef SYNTH
`define MLBA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlba: same-cycle check failed");
`define MLBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlba: next-cycle check failed");
`else
`define MLBA_ASSERT_SAME(lbl, ante, cons)
`define MLBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/mlba_pkg.sv =====
// Shared types and constants of the multilook box average decimator.
// No dependencies.
`timescale 1ns / 1ps

package mlba_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int LOOK_W    = 5;
  localparam int PER_W     = 10;
  localparam int DV_W      = 10;
  localparam int COL_W     = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int SKIP_MAX  = 16;

  localparam logic [COL_W-1:0] CNT_MAX = {COL_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 3'd6;

  // Effective geometry after clamping the registers
  typedef struct packed {
    logic [LOOK_W-1:0] lr;
    logic [LOOK_W-1:0] lc;
    logic [PER_W-1:0]  rper;
    logic [PER_W-1:0]  cper;
    logic [COL_W-1:0]  lw;
    logic [COL_W-1:0]  oc;
    logic [COL_W-1:0]  rows;
    logic [DV_W-1:0]   area;
  } geo_t;

  // Where the current sample falls
  typedef struct packed {
    logic             hit;
    logic             first;
    logic             last;
    logic             eor;
    logic             eof;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic logic [LOOK_W-1:0] clamp_skip(input logic [LOOK_W-1:0] v);
    logic [LOOK_W-1:0] r;
    if (v == '0) begin
      r = LOOK_W'(1);
    end else if (v > LOOK_W'(SKIP_MAX)) begin
      r = LOOK_W'(SKIP_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/multilook_box_average_decimator.sv =====
// Multilook box average decimator: one image channel in, box means out. A
// sample outside every kept box is taken while the block stays idle, a
// sample that adds to a box goes through the memory read, then the add and
// write back, and the last sample of a box then waits for the divider, which
// produces one quotient bit per cycle, and for a free output register. The
// finished mean sits in an output register, so the next sample is taken
// while it waits. The accumulator memory needs no clearing pass: every box
// loads its accumulator on its first sample.
// Depends on mlba_pkg, mlba_pos, mlba_ctrl, mlba_dp and the defines header.
`timescale 1ns / 1ps
`include "multilook_box_average_decimator_defines.svh"

module multilook_box_average_decimator #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_LOOK = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] sample
  input  logic [0:0]                     in_tuser,   // [0] frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] mean
  output logic                           out_tlast,  // end_of_row
  output logic [0:0]                     out_tuser,  // [0] end_of_frame
  input  logic                           cfg_wr_en,
  input  logic [mlba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlba_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int LW        = mlba_pkg::LOOK_W;
  localparam int CW        = mlba_pkg::COL_W;
  localparam int PW        = mlba_pkg::PER_W;
  localparam int DW        = mlba_pkg::DV_W;
  localparam int LOOK_CAP  = (MAX_LOOK > 31) ? 31 : MAX_LOOK;
  localparam int OC_CAP    = (MAX_COLS > 8191) ? 8191 : MAX_COLS;

  logic [CW-1:0] line_width_r, out_cols_r, out_rows_r;
  logic [LW-1:0] look_rows_r, look_cols_r, skip_rows_r, skip_cols_r;
  logic [LW-1:0] lr, lc, sr, sc;

  mlba_pkg::geo_t geo;
  mlba_pkg::pos_t pos;
  mlba_pkg::cmd_t cmd;
  mlba_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= CW'(4096);
      look_rows_r  <= LW'(1);
      look_cols_r  <= LW'(1);
      skip_rows_r  <= LW'(1);
      skip_cols_r  <= LW'(1);
      out_cols_r   <= '0;
      out_rows_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mlba_pkg::REG_LINE_WIDTH: line_width_r <= cfg_wdata;
        mlba_pkg::REG_LOOK_ROWS:  look_rows_r  <= cfg_wdata[LW-1:0];
        mlba_pkg::REG_LOOK_COLS:  look_cols_r  <= cfg_wdata[LW-1:0];
        mlba_pkg::REG_SKIP_ROWS:  skip_rows_r  <= cfg_wdata[LW-1:0];
        mlba_pkg::REG_SKIP_COLS:  skip_cols_r  <= cfg_wdata[LW-1:0];
        mlba_pkg::REG_OUT_COLS:   out_cols_r   <= cfg_wdata;
        mlba_pkg::REG_OUT_ROWS:   out_rows_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero acts as one; looks saturate at the build limit
  assign lr = (look_rows_r == '0) ? LW'(1) :
              (look_rows_r > LW'(LOOK_CAP)) ? LW'(LOOK_CAP) : look_rows_r;
  assign lc = (look_cols_r == '0) ? LW'(1) :
              (look_cols_r > LW'(LOOK_CAP)) ? LW'(LOOK_CAP) : look_cols_r;
  assign sr = mlba_pkg::clamp_skip(skip_rows_r);
  assign sc = mlba_pkg::clamp_skip(skip_cols_r);

  always_comb begin
    geo.lr   = lr;
    geo.lc   = lc;
    geo.rper = PW'(lr) * PW'(sr);
    geo.cper = PW'(lc) * PW'(sc);
    geo.lw   = (line_width_r == '0) ? CW'(1) : line_width_r;
    geo.oc   = (out_cols_r > CW'(OC_CAP)) ? CW'(OC_CAP) : out_cols_r;
    geo.rows = out_rows_r;
    geo.area = DW'(lr) * DW'(lc);
  end

  mlba_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (cmd.load),
    .frame_start (in_tuser[0]),
    .geo         (geo),
    .pos         (pos)
  );

  mlba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pos_hit   (pos.hit),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlba_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_LOOK (MAX_LOOK)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .pos          (pos),
    .sample       (in_tdata),
    .area         (geo.area),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .mean         (out_tdata),
    .end_of_row   (out_tlast),
    .end_of_frame (out_tuser[0])
  );

  // A kept sample takes the block busy for the accumulate step
  `MLBA_ASSERT_NEXT(a_hit_goes_busy, in_tvalid && in_tready && pos.hit, !in_tready)
  // A dropped sample leaves the block ready for the next transaction
  `MLBA_ASSERT_NEXT(a_drop_stays_ready, in_tvalid && in_tready && !pos.hit, in_tready)
  // Frame end is only flagged on the last pixel of a row
  `MLBA_ASSERT_SAME(a_eof_on_eor, out_tvalid && out_tuser[0], out_tlast)

endmodule

// ===== rtl/mlba_pos.sv =====
// Raster position counters: window phases, input column, output row/column.
// Depends on mlba_pkg.
`timescale 1ns / 1ps

module mlba_pos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          frame_start,
  input  mlba_pkg::geo_t geo,
  output mlba_pkg::pos_t pos
);

  localparam int PW = mlba_pkg::PER_W;
  localparam int CW = mlba_pkg::COL_W;

  logic [PW-1:0] rp_r, rp_nxt, cp_r, cp_nxt;
  logic [CW-1:0] icol_r, icol_nxt, ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic [PW-1:0] rp_e, cp_e;
  logic [CW-1:0] icol_e, ocol_e, orow_e;
  logic [PW-1:0] lr_x, lc_x;

  // frame_start clears the counters before this sample is placed
  assign rp_e   = frame_start ? '0 : rp_r;
  assign cp_e   = frame_start ? '0 : cp_r;
  assign icol_e = frame_start ? '0 : icol_r;
  assign ocol_e = frame_start ? '0 : ocol_r;
  assign orow_e = frame_start ? '0 : orow_r;

  assign lr_x = PW'(geo.lr);
  assign lc_x = PW'(geo.lc);

  always_comb begin
    pos.hit   = (rp_e < lr_x) && (cp_e < lc_x) && (ocol_e < geo.oc) && (orow_e < geo.rows);
    pos.first = (rp_e == '0) && (cp_e == '0);
    pos.last  = (rp_e == lr_x - PW'(1)) && (cp_e == lc_x - PW'(1));
    pos.eor   = (ocol_e == geo.oc - CW'(1));
    pos.eof   = pos.eor && (orow_e == geo.rows - CW'(1));
    pos.col   = ocol_e;
  end

  always_comb begin
    rp_nxt   = rp_e;
    cp_nxt   = cp_e;
    icol_nxt = icol_e;
    ocol_nxt = ocol_e;
    orow_nxt = orow_e;
    if ({1'b0, cp_e} + (PW+1)'(1) >= {1'b0, geo.cper}) begin
      cp_nxt = '0;
      if (ocol_e < mlba_pkg::CNT_MAX) begin
        ocol_nxt = ocol_e + CW'(1);
      end
    end else begin
      cp_nxt = cp_e + PW'(1);
    end
    if ({1'b0, icol_e} + (CW+1)'(1) >= {1'b0, geo.lw}) begin
      icol_nxt = '0;
      cp_nxt   = '0;
      ocol_nxt = '0;
      if ({1'b0, rp_e} + (PW+1)'(1) >= {1'b0, geo.rper}) begin
        rp_nxt = '0;
        if (orow_e < mlba_pkg::CNT_MAX) begin
          orow_nxt = orow_e + CW'(1);
        end
      end else begin
        rp_nxt = rp_e + PW'(1);
      end
    end else begin
      icol_nxt = icol_e + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      cp_r   <= '0;
      icol_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else if (advance) begin
      rp_r   <= rp_nxt;
      cp_r   <= cp_nxt;
      icol_r <= icol_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

endmodule

// ===== rtl/mlba_ctrl.sv =====
// Sequencer: accept, accumulate, divide and hand off one transaction at a time.
// Depends on mlba_pkg.
`timescale 1ns / 1ps

module mlba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           pos_hit,
  input  mlba_pkg::sts_t sts,
  output mlba_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (pos_hit) begin
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mlba_dp.sv =====
// Datapath: column accumulator memory, adder, bit-serial divider, output register.
// Depends on mlba_pkg.
`timescale 1ns / 1ps

module mlba_dp #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_LOOK = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlba_pkg::cmd_t                cmd,
  output mlba_pkg::sts_t                sts,
  input  mlba_pkg::pos_t                pos,
  input  logic [mlba_pkg::SAMPLE_W-1:0] sample,
  input  logic [mlba_pkg::DV_W-1:0]     area,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mlba_pkg::SAMPLE_W-1:0] mean,
  output logic                          end_of_row,
  output logic                          end_of_frame
);

  localparam int SW     = mlba_pkg::SAMPLE_W;
  localparam int DW     = mlba_pkg::DV_W;
  localparam int SUM_W  = SW + 2 * $clog2(MAX_LOOK);
  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int EXT_W  = (ADDR_W > mlba_pkg::COL_W) ? ADDR_W : mlba_pkg::COL_W;
  localparam int CNT_W  = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  mem [MAX_COLS];
  logic [SUM_W-1:0]  rd_r;
  logic [SW-1:0]     sample_r;
  logic              first_r, last_r, eor_r, eof_r;
  logic [ADDR_W-1:0] addr_r;
  logic [EXT_W-1:0]  col_ext;
  logic [SUM_W-1:0]  sum, sample_x, mag;

  logic [SUM_W-1:0]  q_r;
  logic [DW-1:0]     rem_r, div_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW:0]       rem_sh, rem_diff;
  logic              ge;
  logic [SUM_W-1:0]  q_signed;

  logic [SW-1:0]     mean_r;
  logic              out_valid_r, eor_out_r, eof_out_r;

  assign col_ext  = EXT_W'(pos.col);
  assign sample_x = SUM_W'(signed'(sample_r));
  assign sum      = first_r ? sample_x : rd_r + sample_x;
  assign mag      = sum[SUM_W-1] ? -sum : sum;

  // Restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_r, q_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign q_signed = neg_r ? -q_r : q_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample;
      first_r  <= pos.first;
      last_r   <= pos.last;
      eor_r    <= pos.eor;
      eof_r    <= pos.eof;
      addr_r   <= col_ext[ADDR_W-1:0];
      rd_r     <= mem[col_ext[ADDR_W-1:0]];
    end
    if (cmd.acc) begin
      mem[addr_r] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.acc && last_r) begin
      cnt_r <= CNT_W'(SUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && last_r) begin
      q_r   <= mag;
      rem_r <= '0;
      div_r <= area;
      neg_r <= sum[SUM_W-1];
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mean_r    <= q_signed[SW-1:0];
      eor_out_r <= eor_r;
      eof_out_r <= eof_r;
    end
  end

  assign sts.last     = last_r;
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid   = out_valid_r;
  assign mean         = mean_r;
  assign end_of_row   = eor_out_r;
  assign end_of_frame = eof_out_r;

endmodule
